// ===== rtl/extended_hamming_secded_codec_unit_defines.svh =====
// ---------------------------------------------------------------------------
// SECDED codec assertion macros
// Shared assertion forms for the codec's checker.
// ---------------------------------------------------------------------------
`ifndef EXTENDED_HAMMING_SECDED_CODEC_UNIT_DEFINES_SVH
`define EXTENDED_HAMMING_SECDED_CODEC_UNIT_DEFINES_SVH

// Overlapping implication, sampled on the rising clock edge, off during reset.
`define EHSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Non-overlapping implication, sampled on the rising clock edge, off during reset.
`define EHSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ehsc_pkg.sv =====
// ---------------------------------------------------------------------------
// SECDED codec package
// Transaction types, codes and bit placement functions of the (64,57) codec.
// ---------------------------------------------------------------------------
package ehsc_pkg;

    localparam int CW_W           = 64;
    localparam int DATA_W         = 57;
    localparam int SYN_MAX_W      = 6;
    localparam int BLOCK_BITS_DEF = 64;

    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    localparam logic [1:0] STATUS_CLEAN     = 2'd0;
    localparam logic [1:0] STATUS_CORRECTED = 2'd1;
    localparam logic [1:0] STATUS_DOUBLE    = 2'd2;

    typedef struct packed {
        logic              kind;
        logic [DATA_W-1:0] data_in;
        logic [CW_W-1:0]   codeword_in;
    } item_t;

    typedef struct packed {
        logic [CW_W-1:0]   codeword_out;
        logic [DATA_W-1:0] data_out;
        logic [1:0]        status;
    } result_t;

    typedef struct packed {
        logic            kind;
        logic [CW_W-1:0] cw;
    } stage1_t;

    typedef struct packed {
        logic                 kind;
        logic [CW_W-1:0]      cw;
        logic [SYN_MAX_W-1:0] syn;
        logic                 par;
    } stage2_t;

    function automatic logic [CW_W-1:0] block_mask(int bb);
        logic [CW_W-1:0] m;
        m = '0;
        for (int i = 0; i < CW_W; i++) begin
            m[i] = (i < bb);
        end
        return m;
    endfunction

    function automatic logic [CW_W-1:0] syn_mask(int b, int bb);
        logic [CW_W-1:0] m;
        m = '0;
        for (int i = 1; i < CW_W; i++) begin
            m[i] = (i < bb) && (((i >> b) & 1) != 0);
        end
        return m;
    endfunction

    function automatic logic [CW_W-1:0] place_data(logic [DATA_W-1:0] d, int bb);
        logic [CW_W-1:0] cw;
        int              k;
        cw = '0;
        k  = 0;
        for (int i = 1; i < CW_W; i++) begin
            if (i < bb && (i & (i - 1)) != 0) begin
                if (k < DATA_W) begin
                    cw[i] = d[k];
                end
                k++;
            end
        end
        return cw;
    endfunction

    function automatic logic [DATA_W-1:0] extract_data(logic [CW_W-1:0] cw, int bb);
        logic [DATA_W-1:0] d;
        int                k;
        d = '0;
        k = 0;
        for (int i = 1; i < CW_W; i++) begin
            if (i < bb && (i & (i - 1)) != 0) begin
                if (k < DATA_W) begin
                    d[k] = cw[i];
                end
                k++;
            end
        end
        return d;
    endfunction

endpackage

// ===== rtl/ehsc_place.sv =====
// ---------------------------------------------------------------------------
// SECDED codec input stage
// Places encode data at the data positions or masks a received codeword.
// ---------------------------------------------------------------------------
module ehsc_place #(
    parameter int BLOCK_BITS = ehsc_pkg::BLOCK_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              stall,
    input  ehsc_pkg::item_t   item,
    output logic              stage_valid,
    input  logic              stage_ready,
    output ehsc_pkg::stage1_t stage
);

    localparam logic [ehsc_pkg::CW_W-1:0] BLK_MASK = ehsc_pkg::block_mask(BLOCK_BITS);

    logic              valid_reg;
    logic              ready;
    ehsc_pkg::stage1_t data_reg;
    ehsc_pkg::stage1_t data_next;

    assign ready = !valid_reg || stage_ready;
    assign stall = !ready;

    always_comb
    begin
        data_next.kind = item.kind;
        if (item.kind == ehsc_pkg::KIND_DECODE)
        begin
            data_next.cw = item.codeword_in & BLK_MASK;
        end
        else
        begin
            data_next.cw = ehsc_pkg::place_data(item.data_in, BLOCK_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && valid)
        begin
            data_reg <= data_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage       = data_reg;

endmodule

// ===== rtl/ehsc_syn.sv =====
// ---------------------------------------------------------------------------
// SECDED codec syndrome stage
// Computes the position syndrome and the overall parity of the block.
// ---------------------------------------------------------------------------
module ehsc_syn #(
    parameter int BLOCK_BITS = ehsc_pkg::BLOCK_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  ehsc_pkg::stage1_t up,
    output logic              stage_valid,
    input  logic              stage_ready,
    output ehsc_pkg::stage2_t stage
);

    logic              valid_reg;
    ehsc_pkg::stage2_t data_reg;
    ehsc_pkg::stage2_t data_next;

    assign up_ready = !valid_reg || stage_ready;

    always_comb
    begin
        data_next.kind = up.kind;
        data_next.cw   = up.cw;
        data_next.par  = ^up.cw;
        for (int b = 0; b < ehsc_pkg::SYN_MAX_W; b++)
        begin
            data_next.syn[b] = ^(up.cw & ehsc_pkg::syn_mask(b, BLOCK_BITS));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage       = data_reg;

endmodule

// ===== rtl/ehsc_fix.sv =====
// ---------------------------------------------------------------------------
// SECDED codec result stage
// Inserts check bits on encode; corrects, classifies and extracts on decode.
// ---------------------------------------------------------------------------
module ehsc_fix #(
    parameter int BLOCK_BITS = ehsc_pkg::BLOCK_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  ehsc_pkg::stage2_t up,
    output logic              result_valid,
    input  logic              result_stall,
    output ehsc_pkg::result_t result
);

    logic                             valid_reg;
    ehsc_pkg::result_t                data_reg;
    ehsc_pkg::result_t                data_next;
    logic [ehsc_pkg::CW_W-1:0]        cw_enc;
    logic [ehsc_pkg::CW_W-1:0]        cw_dec;
    logic [ehsc_pkg::CW_W-1:0]        flip;
    logic [1:0]                       status_dec;

    assign up_ready = !valid_reg || !result_stall;
    assign flip     = ehsc_pkg::CW_W'(1) << up.syn;

    always_comb
    begin
        cw_enc = up.cw;
        for (int j = 0; j < ehsc_pkg::SYN_MAX_W; j++)
        begin
            if ((1 << j) < BLOCK_BITS)
            begin
                cw_enc[1 << j] = up.syn[j];
            end
        end
        cw_enc[0] = up.par ^ (^up.syn);
    end

    always_comb
    begin
        cw_dec     = up.cw;
        status_dec = ehsc_pkg::STATUS_CLEAN;
        if (up.syn == '0)
        begin
            if (up.par)
            begin
                cw_dec[0]  = ~up.cw[0];
                status_dec = ehsc_pkg::STATUS_CORRECTED;
            end
        end
        else if (up.par)
        begin
            if (int'(up.syn) < BLOCK_BITS)
            begin
                cw_dec     = up.cw ^ flip;
                status_dec = ehsc_pkg::STATUS_CORRECTED;
            end
            else
            begin
                status_dec = ehsc_pkg::STATUS_DOUBLE;
            end
        end
        else
        begin
            status_dec = ehsc_pkg::STATUS_DOUBLE;
        end
    end

    always_comb
    begin
        if (up.kind == ehsc_pkg::KIND_DECODE)
        begin
            data_next.codeword_out = cw_dec;
            data_next.data_out     = ehsc_pkg::extract_data(cw_dec, BLOCK_BITS);
            data_next.status       = status_dec;
        end
        else
        begin
            data_next.codeword_out = cw_enc;
            data_next.data_out     = '0;
            data_next.status       = ehsc_pkg::STATUS_CLEAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

// ===== rtl/extended_hamming_secded_codec_unit.sv =====
// ---------------------------------------------------------------------------
// Extended Hamming SECDED (64,57) codec
// Each accepted transaction passes the place, syndrome and fix stage registers.
// Throughput is one transaction per cycle while the output is not stalled; every stage holds one transaction.
// The pipeline stalls stage by stage, so bubbles close up under a stalled output.
// Reset clears the stage valid bits; the stage data registers are not reset.
// ---------------------------------------------------------------------------
module extended_hamming_secded_codec_unit #(
    parameter int BLOCK_BITS = ehsc_pkg::BLOCK_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  ehsc_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output ehsc_pkg::result_t result
);

    logic              s1_valid;
    logic              s1_ready;
    ehsc_pkg::stage1_t s1;
    logic              s2_valid;
    logic              s2_ready;
    ehsc_pkg::stage2_t s2;

    ehsc_place #(
        .BLOCK_BITS(BLOCK_BITS)
    ) u_place (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (item_valid),
        .stall      (item_stall),
        .item       (item),
        .stage_valid(s1_valid),
        .stage_ready(s1_ready),
        .stage      (s1)
    );

    ehsc_syn #(
        .BLOCK_BITS(BLOCK_BITS)
    ) u_syn (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s1_valid),
        .up_ready   (s1_ready),
        .up         (s1),
        .stage_valid(s2_valid),
        .stage_ready(s2_ready),
        .stage      (s2)
    );

    ehsc_fix #(
        .BLOCK_BITS(BLOCK_BITS)
    ) u_fix (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (s2_valid),
        .up_ready    (s2_ready),
        .up          (s2),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

endmodule

// ===== rtl/ehsc_checker.sv =====
// ---------------------------------------------------------------------------
// SECDED codec port checker
// Checks latency, stall behavior and result format at the codec's ports.
// ---------------------------------------------------------------------------
`include "extended_hamming_secded_codec_unit_defines.svh"

module ehsc_checker #(
    parameter int BLOCK_BITS = ehsc_pkg::BLOCK_BITS_DEF
) (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input ehsc_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_stall,
    input ehsc_pkg::result_t result
);

    localparam logic [ehsc_pkg::CW_W-1:0] BLK_MASK = ehsc_pkg::block_mask(BLOCK_BITS);

    logic accepted;

    assign accepted = item_valid && !item_stall && (item.kind == ehsc_pkg::KIND_ENCODE ||
                                                    item.kind == ehsc_pkg::KIND_DECODE);

    // A stalled result must stay valid and unchanged.
    `EHSC_ASSERT_NEXT(a_result_hold, clk, rst_n,
                      result_valid && result_stall,
                      result_valid && $stable(result),
                      "stalled result changed")

    // An empty output stage means the whole pipeline can take a transaction.
    `EHSC_ASSERT_SAME(a_empty_accepts, clk, rst_n,
                      !result_valid,
                      !item_stall,
                      "input stalled with empty output stage")

    // With the output free, an accepted transaction passes the stage registers and a result is then valid.
    `EHSC_ASSERT_NEXT(a_latency, clk, rst_n,
                      accepted ##1 !result_stall ##1 !result_stall,
                      result_valid,
                      "result missing after three cycles")

    // Results never carry the reserved status code or bits beyond the block.
    `EHSC_ASSERT_SAME(a_result_format, clk, rst_n,
                      result_valid,
                      (result.status <= ehsc_pkg::STATUS_DOUBLE) &&
                      ((result.codeword_out & ~BLK_MASK) == '0),
                      "malformed result")

endmodule

bind extended_hamming_secded_codec_unit ehsc_checker #(
    .BLOCK_BITS(BLOCK_BITS)
) u_ehsc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
);

// ===== tb/tb_extended_hamming_secded_codec_unit.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the extended Hamming SECDED (64,57) codec
// A directed set of encode and decode transactions covers the data extremes,
// clean words, single errors in data, check and overall parity positions,
// double errors and a triple error. It is followed by random bursts that are
// mostly encoded words with injected errors. A scoreboard predicts every
// result and checks the outputs field by field while both handshakes idle
// and stall at random.
// ---------------------------------------------------------------------------
module tb_extended_hamming_secded_codec_unit;

    localparam int RANDOM_ITEMS = 1950;
    localparam int FLOOD_AT     = 600;
    localparam int DRAIN_AT     = 1200;
    localparam int FLOOD_ITEMS  = 40;
    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 200000;

    class secded_scoreboard;
        ehsc_pkg::result_t expected_results[$];
        int                mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        static function logic [5:0] index_xor(logic [63:0] cw);
            logic [5:0] acc;
            acc = '0;
            for (int i = 1; i < 64; i++)
            begin
                if (cw[i])
                begin
                    acc ^= 6'(i);
                end
            end
            return acc;
        endfunction

        static function logic [63:0] encode_block(logic [56:0] d);
            logic [63:0] cw;
            logic [5:0]  chk;
            int          k;
            cw = '0;
            k  = 0;
            for (int i = 3; i < 64; i++)
            begin
                if ((i & (i - 1)) != 0)
                begin
                    cw[i] = d[k];
                    k++;
                end
            end
            chk = index_xor(cw);
            for (int b = 0; b < 6; b++)
            begin
                cw[1 << b] = chk[b];
            end
            cw[0] = ^cw;
            return cw;
        endfunction

        static function logic [56:0] pull_payload(logic [63:0] cw);
            logic [56:0] d;
            int          k;
            d = '0;
            k = 0;
            for (int i = 3; i < 64; i++)
            begin
                if ((i & (i - 1)) != 0)
                begin
                    d[k] = cw[i];
                    k++;
                end
            end
            return d;
        endfunction

        static function ehsc_pkg::result_t predict_result(ehsc_pkg::item_t t);
            ehsc_pkg::result_t r;
            logic [63:0]       cw;
            logic [5:0]        chk;
            r.status = ehsc_pkg::STATUS_CLEAN;
            if (t.kind == ehsc_pkg::KIND_ENCODE)
            begin
                r.codeword_out = encode_block(t.data_in);
                r.data_out     = '0;
            end
            else
            begin
                cw  = t.codeword_in;
                chk = index_xor(cw);
                if (^cw)
                begin
                    cw[chk]  = ~cw[chk];
                    r.status = ehsc_pkg::STATUS_CORRECTED;
                end
                else if (chk != 0)
                begin
                    r.status = ehsc_pkg::STATUS_DOUBLE;
                end
                r.codeword_out = cw;
                r.data_out     = pull_payload(cw);
            end
            return r;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatch_count++;
        endtask

        function void note_item(ehsc_pkg::item_t t);
            expected_results.push_back(predict_result(t));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task check_result(ehsc_pkg::result_t got);
            ehsc_pkg::result_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with no transaction pending");
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.codeword_out !== want.codeword_out)
                begin
                    report_mismatch($sformatf("codeword_out %h, expected %h",
                                              got.codeword_out, want.codeword_out));
                end
                if (got.data_out !== want.data_out)
                begin
                    report_mismatch($sformatf("data_out %h, expected %h",
                                              got.data_out, want.data_out));
                end
                if (got.status !== want.status)
                begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got.status, want.status));
                end
            end
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    ehsc_pkg::item_t   item;
    logic              result_valid;
    logic              result_stall;
    ehsc_pkg::result_t result;

    secded_scoreboard sb;
    bit               hold_request;
    bit               hold_active;
    int               cycle_count;

    extended_hamming_secded_codec_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("extended_hamming_secded_codec_unit test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            sb.check_result(result);
        end
    end

    initial
    begin
        int mode;
        int run_len;
        result_stall = 1'b0;
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_active  = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
            end
            else
            begin
                mode    = $urandom_range(0, 3);
                run_len = $urandom_range(4, 50);
                while (run_len > 0 && !hold_request)
                begin
                    case (mode)
                        0:       result_stall <= 1'b0;
                        1:       result_stall <= ($urandom_range(0, 3) == 0);
                        2:       result_stall <= $urandom_range(0, 1);
                        default: result_stall <= ($urandom_range(0, 4) != 0);
                    endcase
                    @(posedge clk);
                    run_len--;
                end
            end
        end
    end

    function automatic ehsc_pkg::item_t make_item(logic kind, logic [56:0] d,
                                                  logic [63:0] cw);
        ehsc_pkg::item_t t;
        t.kind        = kind;
        t.data_in     = d;
        t.codeword_in = cw;
        return t;
    endfunction

    function automatic logic [56:0] random_payload();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 57'd1 << $urandom_range(0, 56);
            3:       return ~(57'd1 << $urandom_range(0, 56));
            default: return 57'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [63:0] inject_errors(logic [63:0] cw, int count);
        logic [63:0] flips;
        flips = '0;
        while ($countones(flips) < count)
        begin
            flips[$urandom_range(0, 63)] = 1'b1;
        end
        return cw ^ flips;
    endfunction

    function automatic ehsc_pkg::item_t random_transaction();
        ehsc_pkg::item_t t;
        int              pick;
        int              roll;
        t.kind        = ehsc_pkg::KIND_DECODE;
        t.data_in     = random_payload();
        t.codeword_in = {$urandom, $urandom};
        pick          = $urandom_range(0, 99);
        roll          = $urandom_range(0, 9);
        if (pick < 35)
        begin
            t.kind = ehsc_pkg::KIND_ENCODE;
        end
        else if (pick < 88)
        begin
            t.codeword_in = inject_errors(secded_scoreboard::encode_block(random_payload()),
                                          (roll < 3) ? 0 : (roll < 7) ? 1 : (roll < 9) ? 2 : 3);
        end
        return t;
    endfunction

    task send_item(ehsc_pkg::item_t t);
        item       <= t;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        sb.note_item(t);
    endtask

    task idle_cycles(int count);
        item_valid <= 1'b0;
        repeat (count) @(posedge clk);
    endtask

    task wait_for_drain();
        item_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    initial
    begin
        ehsc_pkg::item_t directed[$];
        logic [63:0]     base;
        int              sent;
        int              burst;
        bit              flooded;
        bit              drained;

        sb           = new();
        cycle_count  = 0;
        hold_request = 1'b0;
        hold_active  = 1'b0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        base = secded_scoreboard::encode_block(57'h123_4567_89AB_CDEF);
        directed.push_back(make_item(ehsc_pkg::KIND_ENCODE, '0, '0));
        directed.push_back(make_item(ehsc_pkg::KIND_ENCODE, '1, '1));
        directed.push_back(make_item(ehsc_pkg::KIND_ENCODE, 57'(64'h5555_5555_5555_5555), '0));
        directed.push_back(make_item(ehsc_pkg::KIND_ENCODE, 57'(64'hAAAA_AAAA_AAAA_AAAA), '1));
        directed.push_back(make_item(ehsc_pkg::KIND_ENCODE, 57'd1, '0));
        directed.push_back(make_item(ehsc_pkg::KIND_ENCODE, 57'd1 << 56, '0));
        directed.push_back(make_item(ehsc_pkg::KIND_DECODE, '0, base));
        directed.push_back(make_item(ehsc_pkg::KIND_DECODE, '1, '0));
        directed.push_back(make_item(ehsc_pkg::KIND_DECODE, '0, '1));
        directed.push_back(make_item(ehsc_pkg::KIND_DECODE, '0, base ^ 64'd1));
        directed.push_back(make_item(ehsc_pkg::KIND_DECODE, '0, base ^ (64'd1 << 63)));
        directed.push_back(make_item(ehsc_pkg::KIND_DECODE, '0, base ^ (64'd1 << 1)));
        directed.push_back(make_item(ehsc_pkg::KIND_DECODE, '0, base ^ (64'd1 << 32)));
        directed.push_back(make_item(ehsc_pkg::KIND_DECODE, '0, base ^ (64'd1 << 3)));
        directed.push_back(make_item(ehsc_pkg::KIND_DECODE, '0,
                                     base ^ (64'd1 << 5) ^ (64'd1 << 9)));
        directed.push_back(make_item(ehsc_pkg::KIND_DECODE, '0,
                                     base ^ 64'd1 ^ (64'd1 << 63)));
        directed.push_back(make_item(ehsc_pkg::KIND_DECODE, '0,
                                     base ^ (64'd1 << 2) ^ (64'd1 << 7) ^ (64'd1 << 40)));
        directed.push_back(make_item(ehsc_pkg::KIND_DECODE, '1, ~64'd1));
        directed.push_back(make_item(ehsc_pkg::KIND_DECODE, '1,
                                     secded_scoreboard::encode_block('1) ^ (64'd1 << 62)));
        foreach (directed[i])
        begin
            send_item(directed[i]);
        end
        wait_for_drain();

        sent    = 0;
        flooded = 1'b0;
        drained = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            if (!flooded && sent >= FLOOD_AT)
            begin
                // Hold the output while offering back-to-back transactions.
                flooded      = 1'b1;
                hold_request = 1'b1;
                item_valid <= 1'b0;
                do @(posedge clk); while (!hold_active);
                repeat (FLOOD_ITEMS) send_item(random_transaction());
                sent += FLOOD_ITEMS;
            end
            if (!drained && sent >= DRAIN_AT)
            begin
                drained = 1'b1;
                wait_for_drain();
            end
            burst = $urandom_range(1, 40);
            repeat (burst) send_item(random_transaction());
            sent += burst;
            if ($urandom_range(0, 3) != 0)
            begin
                idle_cycles($urandom_range(1, 12));
            end
        end

        wait_for_drain();
        repeat (20) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0)
        begin
            $display("extended_hamming_secded_codec_unit test passed");
        end
        else
        begin
            $display("extended_hamming_secded_codec_unit test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ehsc_pkg.sv
rtl/ehsc_place.sv
rtl/ehsc_syn.sv
rtl/ehsc_fix.sv
rtl/extended_hamming_secded_codec_unit.sv
rtl/ehsc_checker.sv
tb/tb_extended_hamming_secded_codec_unit.sv
